// ===== hdl/epr_pkg.sv =====
// Shared types and constants for the eta/phi region lookup block.
// Used by epr_cell and eta_phi_region_lookup; depends on nothing else.
package epr_pkg;

	localparam int IDX_W    = 6;
	localparam int GRP_W    = 6;
	localparam int REGION_W = 6;
	localparam int COUNT_W  = 7;
	localparam int CFG_W    = 7;
	localparam int CFG_AW   = 2;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam logic [CFG_AW-1:0] REG_COUNT  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_ABS    = 2'd1;
	localparam logic [CFG_AW-1:0] REG_GROUPS = 2'd2;

	typedef struct packed {
		logic vld;
		logic act;
		logic done;
		logic found;
	} epr_ctl_t;

endpackage

// ===== hdl/epr_cell.sv =====
// One table entry of the region chain: holds its bounds and group, applies
// writes aimed at it and resolves passing lookups. Depends on epr_pkg.
module epr_cell
	import epr_pkg::*;
#(
	parameter int K          = 0,
	parameter int COORD_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic [COUNT_W-1:0]                    cfg_count,
	input  logic                                  cfg_groups,
	input  epr_ctl_t                              ctl_in,
	input  logic [REGION_W-1:0]                   region_in,
	input  logic [IDX_W+4*COORD_BITS+GRP_W:0]     wr_in,
	input  logic signed [COORD_BITS:0]            eta_in,
	input  logic signed [COORD_BITS-1:0]          phi_in,
	output epr_ctl_t                              ctl_out,
	output logic [REGION_W-1:0]                   region_out,
	output logic [IDX_W+4*COORD_BITS+GRP_W:0]     wr_out,
	output logic signed [COORD_BITS:0]            eta_out,
	output logic signed [COORD_BITS-1:0]          phi_out
);

	localparam int C     = COORD_BITS;
	localparam int WR_W  = IDX_W + 4 * C + GRP_W + 1;
	localparam int O_ELO = IDX_W;
	localparam int O_EHI = O_ELO + C;
	localparam int O_PLO = O_EHI + C;
	localparam int O_PHI = O_PLO + C;
	localparam int O_GRP = O_PHI + C;
	localparam int O_GV  = O_GRP + GRP_W;

	logic [C-1:0]        elo_q, ehi_q, plo_q, phh_q;
	logic [GRP_W-1:0]    grp_q;
	logic                gv_q;

	epr_ctl_t            ctl_q;
	logic [REGION_W-1:0] region_q;
	logic [WR_W-1:0]     wr_q;
	logic signed [C:0]   eta_q;
	logic signed [C-1:0] phi_q;

	logic [IDX_W-1:0]    wr_idx;
	logic                wr_hit;
	logic signed [C:0]   elo_x, ehi_x;
	logic signed [C-1:0] plo_s, phh_s;
	logic                eta_ok, phi_ok, active, match;
	logic                found_nx;
	logic [REGION_W-1:0] region_nx;

	assign wr_idx = wr_in[IDX_W-1:0];
	assign wr_hit = ctl_in.vld && (ctl_in.act == ACT_WRITE) && (32'(wr_idx) == K);

	assign elo_x  = $signed({elo_q[C-1], elo_q});
	assign ehi_x  = $signed({ehi_q[C-1], ehi_q});
	assign plo_s  = $signed(plo_q);
	assign phh_s  = $signed(phh_q);
	assign eta_ok = (eta_in >= elo_x) && (eta_in < ehi_x);
	assign phi_ok = (plo_s <= phh_s) ? ((phi_in >= plo_s) && (phi_in < phh_s))
	                                 : ((phi_in >= plo_s) || (phi_in < phh_s));
	assign active = (32'(cfg_count) > K);
	assign match  = ctl_in.vld && (ctl_in.act == ACT_LOOKUP) && !ctl_in.done &&
	                active && eta_ok && phi_ok;

	always_comb begin
		found_nx  = ctl_in.found;
		region_nx = region_in;
		if (match) begin
			if (!cfg_groups) begin
				found_nx  = 1'b1;
				region_nx = REGION_W'(K);
			end else begin
				found_nx  = gv_q;
				region_nx = gv_q ? REGION_W'(grp_q) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && wr_hit) begin
			elo_q <= wr_in[O_ELO +: C];
			ehi_q <= wr_in[O_EHI +: C];
			plo_q <= wr_in[O_PLO +: C];
			phh_q <= wr_in[O_PHI +: C];
			grp_q <= wr_in[O_GRP +: GRP_W];
			gv_q  <= wr_in[O_GV];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q.vld   <= ctl_in.vld;
			ctl_q.act   <= ctl_in.act;
			ctl_q.done  <= ctl_in.done | match;
			ctl_q.found <= found_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			region_q <= region_nx;
			wr_q     <= wr_in;
			eta_q    <= eta_in;
			phi_q    <= phi_in;
		end
	end

	assign ctl_out    = ctl_q;
	assign region_out = region_q;
	assign wr_out     = wr_q;
	assign eta_out    = eta_q;
	assign phi_out    = phi_q;

endmodule

// ===== hdl/eta_phi_region_lookup.sv =====
// Top level of the eta/phi region lookup: input unpacking, a chain of
// epr_cell instances and the output register. Depends on epr_pkg, epr_cell.
//
// Usage
// The slave stream carries one transaction per item: s_tuser selects a table
// write (0) or a lookup (1); s_tdata holds the entry fields and coordinates.
// Every transaction walks a chain of MAX_REGIONS cells, one cell per cycle;
// cell k holds table entry k, applies a write aimed at it and checks a
// passing lookup against its region. The first matching cell settles the
// answer, later cells pass it on, so writes and lookups keep their order.
// Each transaction yields one result on the master stream: found and region
// (a write answers found = 0, region = 0).
// A transaction passes the MAX_REGIONS cell registers and then the output
// register; one transaction is taken per cycle while the chain is not held.
// When the receiver stalls with a result held, the whole chain holds and
// s_tready drops until the result is taken. Reset clears the configuration
// registers and all in-flight transactions; table contents are not cleared
// and must be written before use. Configuration is to be written by the user
// through cfg_we/cfg_addr/cfg_wdata while idle; the block does not enforce it.
module eta_phi_region_lookup
	import epr_pkg::*;
#(
	parameter int MAX_REGIONS = 64,
	parameter int COORD_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_AW-1:0]       cfg_addr,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// tdata: entry_index, eta_low, eta_high, phi_low, phi_high, group_index,
	//        group_valid, eta, phi, zero fill
	input  logic [((IDX_W+6*COORD_BITS+GRP_W+1+7)/8)*8-1:0] s_tdata,
	// tuser: action
	input  logic                    s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// tdata: found, region, zero fill
	output logic [7:0]              m_tdata
);

	localparam int C     = COORD_BITS;
	localparam int N     = MAX_REGIONS;
	localparam int WR_W  = IDX_W + 4 * C + GRP_W + 1;

	logic [COUNT_W-1:0] count_q;
	logic               abs_q;
	logic               groups_q;

	logic               en;
	logic               out_vld_q;
	logic               out_found_q;
	logic [REGION_W-1:0] out_region_q;

	logic signed [C-1:0] eta_raw;
	logic signed [C:0]   eta_ext;

	epr_ctl_t            ctl_c    [N+1];
	logic [REGION_W-1:0] region_c [N+1];
	logic [WR_W-1:0]     wr_c     [N+1];
	logic signed [C:0]   eta_c    [N+1];
	logic signed [C-1:0] phi_c    [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			abs_q    <= 1'b0;
			groups_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_COUNT:  count_q  <= cfg_wdata[COUNT_W-1:0];
				REG_ABS:    abs_q    <= cfg_wdata[0];
				REG_GROUPS: groups_q <= cfg_wdata[0];
				default:    ;
			endcase
		end
	end

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	assign eta_raw = $signed(s_tdata[WR_W +: C]);
	assign eta_ext = (abs_q && eta_raw[C-1]) ? -$signed({eta_raw[C-1], eta_raw})
	                                         : $signed({eta_raw[C-1], eta_raw});

	assign ctl_c[0]    = '{vld: s_tvalid, act: s_tuser, done: 1'b0, found: 1'b0};
	assign region_c[0] = '0;
	assign wr_c[0]     = s_tdata[WR_W-1:0];
	assign eta_c[0]    = eta_ext;
	assign phi_c[0]    = $signed(s_tdata[WR_W + C +: C]);

	for (genvar k = 0; k < N; k++) begin : g_cell
		epr_cell #(
			.K          (k),
			.COORD_BITS (C)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.cfg_count  (count_q),
			.cfg_groups (groups_q),
			.ctl_in     (ctl_c[k]),
			.region_in  (region_c[k]),
			.wr_in      (wr_c[k]),
			.eta_in     (eta_c[k]),
			.phi_in     (phi_c[k]),
			.ctl_out    (ctl_c[k+1]),
			.region_out (region_c[k+1]),
			.wr_out     (wr_c[k+1]),
			.eta_out    (eta_c[k+1]),
			.phi_out    (phi_c[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= ctl_c[N].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_found_q  <= ctl_c[N].found;
			out_region_q <= ctl_c[N].found ? region_c[N] : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_region_q, out_found_q};

	`ifndef SYNTH
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[REGION_W:1] == '0)
		else $error("region nonzero without a match");

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready out of step with the output register");

	a_write_nofound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c[N].vld && ctl_c[N].act == ACT_WRITE |-> !ctl_c[N].found)
		else $error("write transaction marked found");

	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c[N].found |-> ctl_c[N].done)
		else $error("found set without a settled match");
	`endif

endmodule

// ===== test/tb_eta_phi_region_lookup.sv =====
// Self-checking testbench for eta_phi_region_lookup: loads region tables,
// runs directed and random lookups and compares every result with a predictor.
// Depends on epr_pkg and the eta_phi_region_lookup RTL.
module tb_eta_phi_region_lookup
	import epr_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REGIONS  = 64;
	localparam int COORD_BITS   = 16;
	localparam int TDATA_W      = ((IDX_W + 6*COORD_BITS + GRP_W + 1 + 7) / 8) * 8;
	localparam int PAD_W        = TDATA_W - (IDX_W + 6*COORD_BITS + GRP_W + 1);
	localparam int PHASE_ITEMS  = 200;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 2 * MAX_REGIONS + 20;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct {
		logic                         act;
		logic [IDX_W-1:0]             idx;
		logic signed [COORD_BITS-1:0] eta_lo;
		logic signed [COORD_BITS-1:0] eta_hi;
		logic signed [COORD_BITS-1:0] phi_lo;
		logic signed [COORD_BITS-1:0] phi_hi;
		logic [GRP_W-1:0]             grp;
		logic                         grp_vld;
		logic signed [COORD_BITS-1:0] eta;
		logic signed [COORD_BITS-1:0] phi;
	} region_item_t;

	typedef struct {
		logic                found;
		logic [REGION_W-1:0] region;
	} region_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_AW-1:0]   cfg_addr = '0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [7:0]          m_tdata;

	region_item_t        region_table [MAX_REGIONS];
	logic [COUNT_W-1:0]  count_cfg;
	logic                abs_cfg;
	logic                groups_cfg;
	region_result_t      pending_results [$];

	int                  errors = 0;
	int                  cycles = 0;
	int                  stall_left = 0;
	bit                  hold_req = 1'b0;
	bit                  sender_gapless = 1'b0;
	bit                  sink_always_ready = 1'b0;

	eta_phi_region_lookup #(
		.MAX_REGIONS(MAX_REGIONS),
		.COORD_BITS (COORD_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap(input int long_max);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(10, long_max);
	endfunction

	function automatic int active_count();
		return (count_cfg > MAX_REGIONS) ? MAX_REGIONS : int'(count_cfg);
	endfunction

	function automatic region_item_t random_fields();
		region_item_t it;
		it.act     = 1'($urandom);
		it.idx     = IDX_W'($urandom);
		it.eta_lo  = COORD_BITS'($urandom);
		it.eta_hi  = COORD_BITS'($urandom);
		it.phi_lo  = COORD_BITS'($urandom);
		it.phi_hi  = COORD_BITS'($urandom);
		it.grp     = GRP_W'($urandom);
		it.grp_vld = 1'($urandom);
		it.eta     = COORD_BITS'($urandom);
		it.phi     = COORD_BITS'($urandom);
		return it;
	endfunction

	function automatic region_item_t make_entry(input int idx, input int el, input int eh,
			input int pl, input int ph, input int grp, input logic vld);
		region_item_t it;
		it         = random_fields();
		it.act     = ACT_WRITE;
		it.idx     = IDX_W'(idx);
		it.eta_lo  = COORD_BITS'(el);
		it.eta_hi  = COORD_BITS'(eh);
		it.phi_lo  = COORD_BITS'(pl);
		it.phi_hi  = COORD_BITS'(ph);
		it.grp     = GRP_W'(grp);
		it.grp_vld = vld;
		return it;
	endfunction

	function automatic region_item_t make_lookup(input int eta, input int phi);
		region_item_t it;
		it     = random_fields();
		it.act = ACT_LOOKUP;
		it.eta = COORD_BITS'(eta);
		it.phi = COORD_BITS'(phi);
		return it;
	endfunction

	function automatic region_item_t random_entry(input int idx);
		region_item_t it;
		int lo;
		int w;
		it     = random_fields();
		it.act = ACT_WRITE;
		it.idx = IDX_W'(idx);
		if ($urandom_range(0, 9) != 0) begin
			lo = int'($urandom_range(0, 65535)) - 32768;
			w  = $urandom_range(1, 6000);
			it.eta_lo = COORD_BITS'(lo);
			it.eta_hi = COORD_BITS'((lo + w > 32767) ? 32767 : lo + w);
			if ($urandom_range(0, 4) == 0) begin
				it.phi_lo = COORD_BITS'($urandom_range(1, 32767));
				it.phi_hi = COORD_BITS'(0 - int'($urandom_range(0, 32768)));
			end else begin
				lo = int'($urandom_range(0, 65535)) - 32768;
				w  = $urandom_range(1, 6000);
				it.phi_lo = COORD_BITS'(lo);
				it.phi_hi = COORD_BITS'((lo + w > 32767) ? 32767 : lo + w);
			end
		end
		return it;
	endfunction

	// Aim most lookups at a randomly chosen active region so matches land throughout the table.
	function automatic region_item_t random_lookup();
		region_item_t it;
		region_item_t ent;
		int n;
		int lo;
		int hi;
		int e;
		int p;
		n  = active_count();
		it = random_fields();
		it.act = ACT_LOOKUP;
		if (n > 0 && $urandom_range(0, 9) < 7) begin
			ent = region_table[$urandom_range(0, n - 1)];
			lo  = int'(ent.eta_lo);
			hi  = int'(ent.eta_hi);
			e   = (lo < hi) ? lo + int'($urandom_range(0, hi - lo - 1)) : int'(it.eta);
			lo  = int'(ent.phi_lo);
			hi  = int'(ent.phi_hi);
			if (lo < hi)
				p = lo + int'($urandom_range(0, hi - lo - 1));
			else if (lo > hi && (hi == -32768 || $urandom_range(0, 1) == 0))
				p = lo + int'($urandom_range(0, 32767 - lo));
			else if (lo > hi)
				p = -32768 + int'($urandom_range(0, hi + 32767));
			else
				p = int'(it.phi);
			if (abs_cfg && $urandom_range(0, 1) == 0)
				e = -e;
			it.eta = COORD_BITS'(e);
			it.phi = COORD_BITS'(p);
		end else if ($urandom_range(0, 3) == 0) begin
			it.eta = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
			it.phi = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
		end
		return it;
	endfunction

	task automatic predict_region(input region_item_t it);
		region_result_t r;
		region_item_t ent;
		int e;
		int p;
		int k;
		bit in_eta;
		bit in_phi;
		r.found  = 1'b0;
		r.region = '0;
		if (it.act == ACT_WRITE) begin
			region_table[it.idx] = it;
		end else begin
			e = int'(it.eta);
			p = int'(it.phi);
			if (abs_cfg && e < 0)
				e = -e;
			for (k = 0; k < active_count(); k++) begin
				ent    = region_table[k];
				in_eta = (e >= int'(ent.eta_lo)) && (e < int'(ent.eta_hi));
				if (ent.phi_lo <= ent.phi_hi)
					in_phi = (p >= int'(ent.phi_lo)) && (p < int'(ent.phi_hi));
				else
					in_phi = (p >= int'(ent.phi_lo)) || (p < int'(ent.phi_hi));
				if (in_eta && in_phi) begin
					if (!groups_cfg) begin
						r.found  = 1'b1;
						r.region = REGION_W'(k);
					end else if (ent.grp_vld) begin
						r.found  = 1'b1;
						r.region = ent.grp;
					end
					break;
				end
			end
		end
		pending_results.insert(pending_results.size(), r);
	endtask

	task automatic send_item(input region_item_t it);
		int gap;
		gap = sender_gapless ? 0 : pick_gap(40);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.act;
		s_tdata  <= {{PAD_W{1'b0}}, it.phi, it.eta, it.grp_vld, it.grp, it.phi_hi,
			it.phi_lo, it.eta_hi, it.eta_lo, it.idx};
		do @(posedge clk); while (!s_tready);
		predict_region(it);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_config(input int count, input logic abs_eta, input logic groups);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_COUNT;
		cfg_wdata <= CFG_W'(count);
		count_cfg  = COUNT_W'(count);
		@(posedge clk);
		cfg_addr  <= REG_ABS;
		cfg_wdata <= CFG_W'(abs_eta);
		abs_cfg    = abs_eta;
		@(posedge clk);
		cfg_addr  <= REG_GROUPS;
		cfg_wdata <= CFG_W'(groups);
		groups_cfg = groups;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_empty_table();
		send_item(make_lookup(-32768, 32767));
		send_item(make_entry(63, 32767, -32768, 32767, -32768, 63, 1'b1));
		send_item(make_lookup(32767, -32768));
		wait_drained();
	endtask

	task automatic test_directed_regions();
		send_item(make_entry(0, -32768, -30000, -32768, 32767, 63, 1'b1));
		send_item(make_entry(1, 0, 1024, 20000, -20000, 0, 1'b0));
		send_item(make_entry(2, 100, 32767, -100, 100, 5, 1'b1));
		send_item(make_entry(3, 0, 0, -32768, 32767, 1, 1'b1));
		send_item(make_entry(4, -32768, 32767, 5, 5, 2, 1'b1));
		send_item(make_entry(5, -32768, 32767, 32767, -32768, 3, 1'b1));
		send_item(make_entry(6, 2000, 3000, -32768, 32767, 42, 1'b0));
		send_item(make_entry(7, -32768, 32767, -32768, 32767, 7, 1'b1));
		wait_drained();
		set_config(8, 1'b0, 1'b0);
		send_item(make_lookup(-32768, 0));
		send_item(make_lookup(500, 30000));
		send_item(make_lookup(500, -30000));
		send_item(make_lookup(500, 0));
		send_item(make_lookup(32767, 32767));
		send_item(make_lookup(-5000, 32767));
		send_item(make_lookup(2500, 5000));
		wait_drained();
		set_config(8, 1'b1, 1'b1);
		send_item(make_lookup(-32768, 0));
		send_item(make_lookup(-2500, 5000));
		send_item(make_lookup(-500, -30000));
		send_item(make_lookup(-200, 50));
		send_item(make_lookup(-5000, 32767));
		wait_drained();
	endtask

	task automatic test_fill_table();
		int i;
		for (i = 0; i < MAX_REGIONS; i++)
			send_item(random_entry(i));
		wait_drained();
	endtask

	task automatic test_random_phases();
		int ph;
		int i;
		int count;
		for (ph = 0; ph < 10; ph++) begin
			case (ph)
				0: count = 64;
				1: count = 1;
				2: count = 0;
				3: count = 127;
				4: count = 65;
				default: begin
					count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
						: $urandom_range(2, 64);
				end
			endcase
			set_config(count, (ph == 1 || ph == 3) ? 1'b1 : 1'($urandom),
				(ph == 1 || ph == 2) ? 1'b1 : 1'($urandom));
			sender_gapless    = (ph == 6);
			sink_always_ready = (ph == 6);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 4) == 0)
					send_item(random_entry($urandom_range(0, MAX_REGIONS - 1)));
				else
					send_item(random_lookup());
			end
			wait_drained();
			sender_gapless    = 1'b0;
			sink_always_ready = 1'b0;
		end
	endtask

	task automatic test_backpressure();
		int i;
		set_config(64, 1'b0, 1'b1);
		hold_req       = 1'b1;
		sender_gapless = 1'b1;
		for (i = 0; i < 150; i++)
			send_item(random_lookup());
		sender_gapless = 1'b0;
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req   = 1'b0;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if (!sink_always_ready)
				stall_left = pick_gap(50);
		end
	end

	always @(posedge clk) begin
		region_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, expected none, actual found=%0b region=%0d",
					$time, m_tdata[0], m_tdata[REGION_W:1]);
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tdata[0] !== exp_r.found) begin
					errors++;
					$display("%0t: found mismatch, expected %0b, actual %0b",
						$time, exp_r.found, m_tdata[0]);
				end
				if (m_tdata[REGION_W:1] !== exp_r.region) begin
					errors++;
					$display("%0t: region mismatch, expected %0d, actual %0d",
						$time, exp_r.region, m_tdata[REGION_W:1]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		count_cfg  = '0;
		abs_cfg    = 1'b0;
		groups_cfg = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_directed_regions();
		test_fill_table();
		test_random_phases();
		test_backpressure();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, pending_results.size());
		end
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/epr_pkg.sv
hdl/epr_cell.sv
hdl/eta_phi_region_lookup.sv
test/tb_eta_phi_region_lookup.sv
